// ===== hdl/orb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants of the overwriting ring buffer
// Holds the command and status codes, the request and response payloads and
// the stage record passed from the pointer stage to the result stage.
// ----------------------------------------------------------------------------
package orb_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_W          = 9;
    localparam int IDX_W          = 8;
    localparam int VAL_W          = 32;

    typedef enum logic [1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP      = 2'd1,
        CMD_READ_IDX = 2'd2,
        CMD_READ_NEW = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] data;
        logic [CAP_W-1:0]        fill_count;
        logic                    is_full;
        logic                    buf_empty;
    } t_rsp;

    // Everything the result stage needs besides the store read data.
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             data_ok;
        logic [CAP_W-1:0] fill_count;
        logic             is_full;
        logic             buf_empty;
    } t_s1;

endpackage

// ===== hdl/orb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ctrl: pointer stage and entry store
// Decodes one accepted request per cycle, updates the head, tail, count and
// full flag, writes pushed values and reads the addressed entry into a data register.
// ----------------------------------------------------------------------------
module orb_ctrl #(
    parameter int DEPTH      = orb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_accept,
    input  orb_pkg::t_req             i_req,
    input  logic [orb_pkg::CAP_W-1:0] i_cap,
    output orb_pkg::t_s1              o_s1,
    output logic [DATA_WIDTH-1:0]     o_rdata
);
    import orb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int AW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0]      r_old, n_old;
    logic [PTR_W-1:0]      r_wr, n_wr;
    logic [CAP_W-1:0]      r_count, n_count;
    logic                  r_full, n_full;
    t_s1                   r_s1, n_s1;

    logic [AW-1:0]         w_cap, w_old_inc, w_wr_inc, w_sum, w_pos, w_last;
    logic [PTR_W-1:0]      w_old_next, w_wr_next, w_old_after;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_we, w_re;
    logic [PTR_W-1:0]      w_raddr;

    // Stored values keep DATA_WIDTH bits of the 32-bit request value.
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_wdata
        if (g < VAL_W) begin : g_bit
            assign w_wdata[g] = i_req.value[g];
        end else begin : g_zero
            assign w_wdata[g] = 1'b0;
        end
    end

    always_comb begin
        w_cap       = AW'(i_cap);
        w_old_inc   = AW'(r_old) + AW'(1);
        w_wr_inc    = AW'(r_wr) + AW'(1);
        w_old_next  = (w_old_inc >= w_cap) ? '0 : PTR_W'(w_old_inc);
        w_wr_next   = (w_wr_inc >= w_cap) ? '0 : PTR_W'(w_wr_inc);
        w_old_after = r_full ? w_old_next : r_old;
        // Head plus age is below twice the capacity, so one subtract wraps it.
        w_sum       = AW'(r_old) + AW'(i_req.index);
        w_pos       = (w_sum >= w_cap) ? (w_sum - w_cap) : w_sum;
        w_last      = (r_wr == '0) ? (w_cap - AW'(1)) : (AW'(r_wr) - AW'(1));
    end

    always_comb begin
        n_old         = r_old;
        n_wr          = r_wr;
        n_count       = r_count;
        n_full        = r_full;
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_raddr       = r_old;
        n_s1.status   = ST_OK;
        n_s1.data_ok  = 1'b0;
        if (i_accept) begin
            case (i_req.cmd)
                CMD_PUSH: begin
                    w_we   = 1'b1;
                    n_wr   = w_wr_next;
                    n_old  = w_old_after;
                    if (!r_full) begin
                        n_count = r_count + CAP_W'(1);
                    end
                    n_full = (w_wr_next == w_old_after);
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        n_s1.status = ST_EMPTY;
                    end else begin
                        w_re         = 1'b1;
                        n_s1.data_ok = 1'b1;
                        n_old        = w_old_next;
                        n_count      = r_count - CAP_W'(1);
                        n_full       = 1'b0;
                    end
                end
                CMD_READ_IDX: begin
                    if (CAP_W'(i_req.index) >= r_count) begin
                        n_s1.status = ST_RANGE;
                    end else begin
                        w_re         = 1'b1;
                        n_s1.data_ok = 1'b1;
                        w_raddr      = PTR_W'(w_pos);
                    end
                end
                CMD_READ_NEW: begin
                    if (r_count == '0) begin
                        n_s1.status = ST_EMPTY;
                    end else begin
                        w_re         = 1'b1;
                        n_s1.data_ok = 1'b1;
                        w_raddr      = PTR_W'(w_last);
                    end
                end
                default: begin
                    n_s1.status = ST_OK;
                end
            endcase
        end
        if (i_clear) begin
            n_old   = '0;
            n_wr    = '0;
            n_count = '0;
            n_full  = 1'b0;
        end
        n_s1.valid      = i_accept;
        n_s1.fill_count = n_count;
        n_s1.is_full    = n_full;
        n_s1.buf_empty  = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old   <= '0;
            r_wr    <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
            r_s1    <= '0;
        end else begin
            r_old   <= n_old;
            r_wr    <= n_wr;
            r_count <= n_count;
            r_full  <= n_full;
            r_s1    <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_s1    = r_s1;
    assign o_rdata = r_rdata;

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i_cap)
        else $error("fill count exceeds capacity");

    a_full_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full == (r_count == i_cap))
        else $error("full flag disagrees with fill count");

    a_ptr_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_old) < w_cap) && (AW'(r_wr) < w_cap))
        else $error("pointer beyond capacity");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_clear && (i_req.cmd == CMD_POP) && (r_count != '0))
        |=> (r_count == CAP_W'($past(r_count) - CAP_W'(1))))
        else $error("pop did not decrement the fill count");

endmodule

// ===== hdl/orb_fmt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_fmt: result stage
// Sign-extends the read entry, zeroes it when nothing was read and registers
// the complete response together with its strobe.
// ----------------------------------------------------------------------------
module orb_fmt #(
    parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  orb_pkg::t_s1          i_s1,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    output logic                  o_valid,
    output orb_pkg::t_rsp         o_rsp
);
    import orb_pkg::*;

    logic [VAL_W-1:0] w_ext;
    logic             r_valid;
    t_rsp             r_rsp, n_rsp;

    for (genvar g = 0; g < VAL_W; g++) begin : g_ext
        if (g < DATA_WIDTH) begin : g_bit
            assign w_ext[g] = i_rdata[g];
        end else begin : g_sign
            assign w_ext[g] = i_rdata[DATA_WIDTH-1];
        end
    end

    always_comb begin
        n_rsp.status     = i_s1.status;
        n_rsp.data       = i_s1.data_ok ? w_ext : '0;
        n_rsp.fill_count = i_s1.fill_count;
        n_rsp.is_full    = i_s1.is_full;
        n_rsp.buf_empty  = i_s1.buf_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hdl/overwriting_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer: circular buffer that overwrites its oldest entry
// Push, pop-oldest, read-at-age and read-newest requests against a store of
// DEPTH entries, of which the capacity register selects how many are in use.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake                  Payload
// request     in         start high, busy low       i_req   (t_req)
// response    out        o_valid, one-cycle strobe  o_rsp   (t_rsp)
// capacity    in         i_cfg_valid & o_cfg_ready  i_cfg_data (9 bits)
//
// One request is accepted in every cycle in which start is high and busy is
// low. The pointer stage registers the store read and the stage record, and
// the result stage registers the formatted response and o_valid after it.
// Reset clears the pointers, the count and the full flag and sets the
// capacity to its default; the entry store itself is not cleared.
// The receiver cannot stall responses, so nothing backs up into the request
// side. busy is high only while a capacity write is presented.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer #(
    parameter int DEPTH      = orb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  orb_pkg::t_req             i_req,
    output logic                      o_valid,
    output orb_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [orb_pkg::CAP_W-1:0] i_cfg_data
);
    import orb_pkg::*;

    // Widest value the capacity register can take, and its reset value.
    localparam int CAP_LIM = (1 << CAP_W) - 1;
    localparam int CAP_MAX = (DEPTH > CAP_LIM) ? CAP_LIM : DEPTH;
    localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;
    localparam int SAT_W   = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;

    logic [CAP_W-1:0] r_cap, n_cap;
    logic             w_cfg_wr;
    logic             w_accept;
    t_s1              w_s1;
    logic [DATA_WIDTH-1:0] w_rdata;

    // A capacity write is always taken; it holds off requests in its cycle so
    // that clearing the pointers never races a request.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign busy        = i_cfg_valid;
    assign w_accept    = start && !busy;

    // Zero is treated as one entry; values above the store depth saturate.
    always_comb begin
        n_cap = r_cap;
        if (w_cfg_wr) begin
            if (i_cfg_data == '0) begin
                n_cap = CAP_W'(1);
            end else if (SAT_W'(i_cfg_data) > SAT_W'(DEPTH)) begin
                n_cap = CAP_W'(CAP_MAX);
            end else begin
                n_cap = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(CAP_RST);
        end else begin
            r_cap <= n_cap;
        end
    end

    orb_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_cfg_wr),
        .i_accept (w_accept),
        .i_req    (i_req),
        .i_cap    (r_cap),
        .o_s1     (w_s1),
        .o_rdata  (w_rdata)
    );

    orb_fmt #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .i_rdata (w_rdata),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== test/overwriting_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_tb: self-checking bench for the overwriting ring buffer
// Drives push, pop, read-at-age and read-newest requests under several
// capacity settings and sender idle patterns. A scoreboard class keeps its own
// copy of the buffer, predicts every response and checks each one field by field.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_tb;
    import orb_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    // The watchdog fires after this many cycles without any transaction.
    localparam int STALL_LIMIT  = 1000;
    // Responses trail their request only through the pointer and result stages.
    localparam int DRAIN_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioral copy of the ring buffer plus the queue of
    // responses that are still owed by the block.
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        logic signed [VAL_W-1:0] entries [STORE_DEPTH];
        int unsigned oldest;
        int unsigned next_wr;
        int unsigned count;
        bit          full;
        int unsigned cap;
        t_rsp        owed_rsps [$];
        int          mismatches;
        int          requests;
        int          responses;

        function new();
            cap = STORE_DEPTH;
            clear_pointers();
        endfunction

        function void clear_pointers();
            oldest  = 0;
            next_wr = 0;
            count   = 0;
            full    = 1'b0;
        endfunction

        function int unsigned advance(int unsigned pos);
            return (pos + 1 >= cap) ? 0 : pos + 1;
        endfunction

        function int pending();
            return owed_rsps.size();
        endfunction

        function int unsigned fill();
            return count;
        endfunction

        // A capacity write empties the buffer. Zero acts as one and anything
        // beyond the store depth saturates to the depth.
        function void set_capacity(logic [CAP_W-1:0] v);
            int unsigned c;
            c = 32'(v);
            if (c == 0) c = 1;
            if (c > STORE_DEPTH) c = STORE_DEPTH;
            cap = c;
            clear_pointers();
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp        = '0;
            rsp.status = ST_OK;
            case (r.cmd)
                CMD_PUSH: begin
                    // A push into a full buffer drops the oldest entry.
                    entries[next_wr] = r.value;
                    next_wr = advance(next_wr);
                    if (full) oldest = advance(oldest);
                    else count++;
                    full = (next_wr == oldest);
                end
                CMD_POP: begin
                    if (count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        rsp.data = entries[oldest];
                        oldest   = advance(oldest);
                        count--;
                        full     = 1'b0;
                    end
                end
                CMD_READ_IDX: begin
                    if (r.index >= count) rsp.status = ST_RANGE;
                    else rsp.data = entries[(oldest + r.index) % cap];
                end
                CMD_READ_NEW: begin
                    if (count == 0) rsp.status = ST_EMPTY;
                    else rsp.data = entries[(next_wr == 0) ? cap - 1 : next_wr - 1];
                end
                default: begin
                    rsp.status = ST_OK;
                end
            endcase
            rsp.fill_count = CAP_W'(count);
            rsp.is_full    = full;
            rsp.buf_empty  = (count == 0);
            owed_rsps.push_back(rsp);
            requests++;
        endfunction

        function void compare(string field, logic signed [63:0] want,
                              logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (owed_rsps.size() == 0) begin
                $error("response with no request outstanding: %p", got);
                mismatches++;
                return;
            end
            want = owed_rsps.pop_front();
            responses++;
            compare("status", 64'(want.status), 64'(got.status));
            compare("data", 64'(want.data), 64'(got.data));
            compare("fill_count", 64'(want.fill_count), 64'(got.fill_count));
            compare("is_full", 64'(want.is_full), 64'(got.is_full));
            compare("buf_empty", 64'(want.buf_empty), 64'(got.buf_empty));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block connections.
    // ------------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             o_valid;
    t_rsp             o_rsp;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    ring_scoreboard sb;
    int             idle_pct;
    int             settings_used;
    int             stall_cycles = 0;

    overwriting_ring_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, while the stimulus
    // only moves at the falling edge, so there is no race with the block.
    // The response is checked before the new request is noted. A response never
    // answers a request of the same edge, so either order would do; this reads best.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_response(o_rsp);
            if (start && !busy) sb.note_request(i_req);
            if (i_cfg_valid && o_cfg_ready) sb.set_capacity(i_cfg_data);
        end
    end

    // The watchdog counts cycles in which no transaction of any kind takes
    // place. A correct run never gets near the limit: sender gaps are short
    // random runs of idle cycles and every response follows its request
    // through the pointer and result stages.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each one is entered just after a falling edge and returns
    // just after a falling edge. start stays high from one request to the next
    // unless the sender decides to pause, so it is never dropped and raised in
    // the same time step. In each cycle the sender idles with the chance set
    // by idle_pct.
    // ------------------------------------------------------------------------
    task automatic send_request(t_cmd cmd, logic signed [VAL_W-1:0] value,
                                logic [IDX_W-1:0] index);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_req = '{cmd: cmd, value: value, index: index};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every owed response has been checked.
    task automatic wait_idle();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // The capacity register is only written with the pipeline empty, since a
    // write clears the pointers under any request still in flight.
    task automatic write_capacity(logic [CAP_W-1:0] v);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings_used++;
    endtask

    // One random request. Reads at an age index mostly target a stored entry,
    // so the interesting path is exercised, but the whole index range still
    // shows up. Value extremes are mixed in with fully random words.
    task automatic random_request(int push_pct, int pop_pct);
        int                      roll;
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        roll = $urandom_range(99);
        if (roll < push_pct) cmd = CMD_PUSH;
        else if (roll < push_pct + pop_pct) cmd = CMD_POP;
        else if ($urandom_range(2) != 0) cmd = CMD_READ_IDX;
        else cmd = CMD_READ_NEW;
        case ($urandom_range(19))
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = '0;
            3: value = '1;
            default: value = $urandom;
        endcase
        if (sb.fill() != 0 && $urandom_range(3) != 0)
            index = IDX_W'($urandom_range(sb.fill() - 1));
        else index = IDX_W'($urandom_range(255));
        send_request(cmd, value, index);
        // Now and then the sender waits for the block to drain completely.
        if ($urandom_range(99) == 0) wait_idle();
    endtask

    task automatic run_phase(logic [CAP_W-1:0] cap_value, int items, int idle,
                             int push_pct, int pop_pct);
        write_capacity(cap_value);
        idle_pct = idle;
        repeat (items) random_request(push_pct, pop_pct);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        sb            = new();
        start         = 1'b0;
        i_req         = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        idle_pct      = 0;
        settings_used = 1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset capacity. Pops and newest reads on an
        // empty buffer report empty, and any index on an empty buffer is out
        // of range. Then the value extremes go in and are read back.
        send_request(CMD_POP, '0, '0);
        send_request(CMD_READ_NEW, '0, '0);
        send_request(CMD_READ_IDX, '0, 8'd0);
        send_request(CMD_READ_IDX, '0, 8'd255);
        send_request(CMD_PUSH, 32'h7fff_ffff, '0);
        send_request(CMD_PUSH, 32'h8000_0000, '0);
        send_request(CMD_PUSH, '0, '0);
        send_request(CMD_PUSH, '1, '0);
        send_request(CMD_READ_IDX, '0, 8'd0);
        send_request(CMD_READ_IDX, '0, 8'd3);
        send_request(CMD_READ_IDX, '0, 8'd4);
        send_request(CMD_READ_NEW, '0, '0);
        send_request(CMD_POP, '0, '0);

        // A capacity of zero acts as one: the second push overwrites the first.
        write_capacity(9'd0);
        send_request(CMD_PUSH, 32'h1234_5678, '0);
        send_request(CMD_PUSH, 32'h8765_4321, '0);
        send_request(CMD_READ_NEW, '0, '0);
        send_request(CMD_READ_IDX, '0, 8'd0);
        send_request(CMD_POP, '0, '0);
        send_request(CMD_POP, '0, '0);

        // Capacity three: the fourth push wraps and drops the oldest entry.
        write_capacity(9'd3);
        send_request(CMD_PUSH, 32'h0000_0011, '0);
        send_request(CMD_PUSH, 32'h0000_0022, '0);
        send_request(CMD_PUSH, 32'h0000_0033, '0);
        send_request(CMD_PUSH, 32'h0000_0044, '0);
        send_request(CMD_READ_IDX, '0, 8'd2);
        send_request(CMD_READ_IDX, '0, 8'd3);
        send_request(CMD_READ_NEW, '0, '0);
        send_request(CMD_POP, '0, '0);

        // Random part. The first phase writes all ones, which saturates to
        // the full depth, and leans on pushes so the buffer fills and keeps
        // overwriting. Later phases mix small, odd and random capacities with
        // the three sender idle patterns.
        run_phase(9'd511, 450, 0, 80, 5);
        run_phase(9'd1, 80, 77, 50, 20);
        run_phase(9'd2, 80, 6, 45, 25);
        run_phase(9'd300, 150, 77, 50, 25);
        run_phase(9'd0, 40, 0, 40, 30);
        run_phase(9'($urandom_range(1, 256)), 100, 6, 55, 20);
        run_phase(9'($urandom_range(1, 256)), 100, 0, 60, 15);
        run_phase(9'($urandom_range(1, 256)), 100, 77, 45, 30);
        run_phase(9'd256, 150, 6, 60, 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked responses across %0d capacity settings.",
                 sb.requests, sb.responses, settings_used);
        $display("Field mismatches seen: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/orb_pkg.sv
hdl/orb_ctrl.sv
hdl/orb_fmt.sv
hdl/overwriting_ring_buffer.sv
test/overwriting_ring_buffer_tb.sv
